// File: design/irht_pkg.sv
// ----------------------------------------------------------------------------
// irht_pkg - shared types and constants of the image region hit test
// Field widths, region slot word, config register indexes and the
// controller/datapath command and status words.
// ----------------------------------------------------------------------------
package irht_pkg;

	localparam int MAX_REGIONS = 64;
	localparam int COORD_W     = 24;
	localparam int ADDR_W      = $clog2(MAX_REGIONS);
	localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
	localparam int TOTAL_W     = 23;
	localparam int DISP_W      = 16;
	localparam int RAD_W       = 23;
	localparam int SLOT_W      = 6;
	localparam int COUNT_W     = 7;
	localparam int PROD_W      = TOTAL_W + DISP_W;
	localparam int DIV_CNT_W   = $clog2(PROD_W);
	localparam int DIFF_W      = COORD_W + 1;
	localparam int SQ_W        = 2 * DIFF_W;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_W       = TOTAL_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOTAL_W   = 3'd0,
		REG_TOTAL_H   = 3'd1,
		REG_DISP_W    = 3'd2,
		REG_DISP_H    = 3'd3,
		REG_MIRROR_H  = 3'd4,
		REG_MIRROR_V  = 3'd5,
		REG_COUNT     = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic                      mode;
		logic [SLOT_W-1:0]         slot;
		logic                      kind;
		logic                      active;
		logic signed [COORD_W-1:0] corner_a_x;
		logic signed [COORD_W-1:0] corner_a_y;
		logic signed [COORD_W-1:0] corner_b_x;
		logic signed [COORD_W-1:0] corner_b_y;
		logic [RAD_W-1:0]          radius;
		logic [DISP_W-1:0]         query_x;
		logic [DISP_W-1:0]         query_y;
	} req_t;

	typedef struct packed {
		logic                      hit_found;
		logic [SLOT_W-1:0]         hit_slot;
		logic signed [COORD_W-1:0] mapped_x;
		logic signed [COORD_W-1:0] mapped_y;
	} rsp_t;

	typedef struct packed {
		logic                      kind;
		logic                      active;
		logic signed [COORD_W-1:0] ax;
		logic signed [COORD_W-1:0] ay;
		logic signed [COORD_W-1:0] bx;
		logic signed [COORD_W-1:0] by;
	} region_t;

	localparam int REGION_W = $bits(region_t);

	typedef struct packed {
		logic              start;
		logic              we;
		logic              div;
		logic              map;
		logic              rd;
		logic              t1;
		logic              t2;
		logic              set_hit;
		logic              out_load;
		logic [ADDR_W-1:0] addr;
	} dp_cmd_t;

	typedef struct packed {
		logic             hit;
		logic [CNT_W-1:0] count;
	} dp_sts_t;

endpackage

// File: design/irht_if.sv
// ----------------------------------------------------------------------------
// irht_if - channel interfaces of the image region hit test
// Request, response and config write channels, each valid/ready.
// ----------------------------------------------------------------------------
interface irht_req_if;
	logic           valid;
	logic           ready;
	irht_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface irht_rsp_if;
	logic           valid;
	logic           ready;
	irht_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface irht_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [irht_pkg::CFG_IDX_W-1:0]      addr;
	logic [irht_pkg::CFG_W-1:0]          data;
	modport source (output valid, output addr, output data, input ready);
	modport sink   (input valid, input addr, input data, output ready);
endinterface

// File: design/irht_ram.sv
// ----------------------------------------------------------------------------
// irht_ram - generic single write, single read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module irht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// File: design/irht_dp.sv
// ----------------------------------------------------------------------------
// irht_dp - datapath of the image region hit test
// Config registers, scaling dividers, region RAM, hit tests, result word.
// ----------------------------------------------------------------------------
module irht_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  irht_pkg::req_t                 req_data,
	input  logic                           cfg_we,
	input  logic [irht_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  logic [irht_pkg::CFG_W-1:0]     cfg_data,
	input  irht_pkg::dp_cmd_t              cmd,
	output irht_pkg::dp_sts_t              sts,
	output irht_pkg::rsp_t                 rsp_data
);
	import irht_pkg::*;

	localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

	logic [TOTAL_W-1:0] total_w_q, total_h_q;
	logic [DISP_W-1:0]  disp_w_q, disp_h_q;
	logic               mirror_h_q, mirror_v_q;
	logic [COUNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_w_q  <= '0;
			total_h_q  <= '0;
			disp_w_q   <= DISP_W'(1);
			disp_h_q   <= DISP_W'(1);
			mirror_h_q <= 1'b0;
			mirror_v_q <= 1'b0;
			count_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_TOTAL_W:  total_w_q  <= cfg_data[TOTAL_W-1:0];
				REG_TOTAL_H:  total_h_q  <= cfg_data[TOTAL_W-1:0];
				REG_DISP_W:   disp_w_q   <= cfg_data[DISP_W-1:0];
				REG_DISP_H:   disp_h_q   <= cfg_data[DISP_W-1:0];
				REG_MIRROR_H: mirror_h_q <= cfg_data[0];
				REG_MIRROR_V: mirror_v_q <= cfg_data[0];
				REG_COUNT:    count_q    <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign sts.count = (32'(count_q) > MAX_REGIONS) ? CNT_W'(MAX_REGIONS) : CNT_W'(count_q);

	// restoring division, one quotient bit a cycle on each axis
	logic [PROD_W-1:0] nx_q, ny_q, qx_q, qy_q;
	logic [DISP_W-1:0] rx_q, ry_q;
	logic [DISP_W-1:0] dvx, dvy;
	logic [DISP_W:0]   tx, ty, sx, sy;
	logic              gex, gey;

	assign dvx = (disp_w_q == '0) ? DISP_W'(1) : disp_w_q;
	assign dvy = (disp_h_q == '0) ? DISP_W'(1) : disp_h_q;
	assign tx  = {rx_q, nx_q[PROD_W-1]};
	assign ty  = {ry_q, ny_q[PROD_W-1]};
	assign gex = tx >= {1'b0, dvx};
	assign gey = ty >= {1'b0, dvy};
	assign sx  = gex ? tx - {1'b0, dvx} : tx;
	assign sy  = gey ? ty - {1'b0, dvy} : ty;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			nx_q <= PROD_W'(total_w_q) * PROD_W'(req_data.query_x);
			ny_q <= PROD_W'(total_h_q) * PROD_W'(req_data.query_y);
			rx_q <= '0;
			ry_q <= '0;
			qx_q <= '0;
			qy_q <= '0;
		end else if (cmd.div) begin
			nx_q <= {nx_q[PROD_W-2:0], 1'b0};
			ny_q <= {ny_q[PROD_W-2:0], 1'b0};
			rx_q <= sx[DISP_W-1:0];
			ry_q <= sy[DISP_W-1:0];
			qx_q <= {qx_q[PROD_W-2:0], gex};
			qy_q <= {qy_q[PROD_W-2:0], gey};
		end
	end

	// saturate, then mirror; total minus a non-negative value stays in range
	logic [COORD_W-1:0] satx, saty, mapx, mapy;
	assign satx = (|qx_q[PROD_W-1:COORD_W-1]) ? COORD_MAX : COORD_W'(qx_q[COORD_W-2:0]);
	assign saty = (|qy_q[PROD_W-1:COORD_W-1]) ? COORD_MAX : COORD_W'(qy_q[COORD_W-2:0]);
	assign mapx = mirror_h_q ? COORD_W'(total_w_q) - satx : satx;
	assign mapy = mirror_v_q ? COORD_W'(total_h_q) - saty : saty;

	logic signed [COORD_W-1:0] map_x_q, map_y_q;
	logic                      res_found_q;
	logic [SLOT_W-1:0]         res_slot_q;

	// region store
	region_t wr_region, rd_region;
	logic    slot_ok;

	assign slot_ok = 32'(req_data.slot) < MAX_REGIONS;

	always_comb begin
		wr_region.kind   = req_data.kind;
		wr_region.active = req_data.active;
		wr_region.ax     = req_data.corner_a_x;
		wr_region.ay     = req_data.corner_a_y;
		if (req_data.kind) begin
			wr_region.bx = COORD_W'(req_data.radius);
			wr_region.by = '0;
		end else begin
			wr_region.bx = req_data.corner_b_x;
			wr_region.by = req_data.corner_b_y;
		end
	end

	irht_ram #(.WIDTH(REGION_W), .DEPTH(MAX_REGIONS)) u_ram (
		.clk   (clk),
		.we    (cmd.we && slot_ok),
		.waddr (ADDR_W'(req_data.slot)),
		.wdata (wr_region),
		.re    (cmd.rd),
		.raddr (cmd.addr),
		.rdata (rd_region)
	);

	// hit test, stage 1: bounds, distances; stage 2: squares
	logic signed [COORD_W-1:0] lox, hix, loy, hiy;
	logic signed [DIFF_W-1:0]  ddx, ddy;
	logic [DIFF_W-1:0]         mdx, mdy;

	assign lox = (rd_region.ax > rd_region.bx) ? rd_region.bx : rd_region.ax;
	assign hix = (rd_region.ax > rd_region.bx) ? rd_region.ax : rd_region.bx;
	assign loy = (rd_region.ay > rd_region.by) ? rd_region.by : rd_region.ay;
	assign hiy = (rd_region.ay > rd_region.by) ? rd_region.ay : rd_region.by;
	assign ddx = DIFF_W'(rd_region.ax) - DIFF_W'(map_x_q);
	assign ddy = DIFF_W'(rd_region.ay) - DIFF_W'(map_y_q);
	assign mdx = ddx[DIFF_W-1] ? -ddx : ddx;
	assign mdy = ddy[DIFF_W-1] ? -ddy : ddy;

	logic              kind_s1, act_s1, rect_s1, neg_s1;
	logic [DIFF_W-1:0] mdx_s1, mdy_s1;
	logic [COORD_W-1:0] r1_s1;
	logic [SQ_W-1:0]   sqx_s2, sqy_s2, r1sq_s2;
	logic [SQ_W:0]     dist_sum;

	always_ff @(posedge clk) begin
		if (cmd.t1) begin
			kind_s1 <= rd_region.kind;
			act_s1  <= rd_region.active;
			rect_s1 <= map_x_q >= lox && map_x_q <= hix && map_y_q >= loy && map_y_q <= hiy;
			neg_s1  <= rd_region.bx[COORD_W-1];
			mdx_s1  <= mdx;
			mdy_s1  <= mdy;
			r1_s1   <= rd_region.bx + COORD_W'(1);
		end
		if (cmd.t2) begin
			sqx_s2  <= SQ_W'(mdx_s1) * SQ_W'(mdx_s1);
			sqy_s2  <= SQ_W'(mdy_s1) * SQ_W'(mdy_s1);
			r1sq_s2 <= SQ_W'(r1_s1) * SQ_W'(r1_s1);
		end
	end

	assign dist_sum = (SQ_W+1)'(sqx_s2) + (SQ_W+1)'(sqy_s2);
	assign sts.hit  = kind_s1 ? (!neg_s1 && dist_sum < (SQ_W+1)'(r1sq_s2)) : rect_s1;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			map_x_q     <= '0;
			map_y_q     <= '0;
			res_found_q <= 1'b0;
			res_slot_q  <= '0;
		end else begin
			if (cmd.map) begin
				map_x_q <= mapx;
				map_y_q <= mapy;
			end
			// first hit ends the walk; an inactive one reports nothing
			if (cmd.set_hit && act_s1) begin
				res_found_q <= 1'b1;
				res_slot_q  <= SLOT_W'(cmd.addr);
			end
		end
		if (cmd.out_load) begin
			rsp_data.hit_found <= res_found_q;
			rsp_data.hit_slot  <= res_slot_q;
			rsp_data.mapped_x  <= map_x_q;
			rsp_data.mapped_y  <= map_y_q;
		end
	end
endmodule

// File: design/irht_ctrl.sv
// ----------------------------------------------------------------------------
// irht_ctrl - controller of the image region hit test
// Sequences division, mapping, the slot walk and the output word.
// ----------------------------------------------------------------------------
module irht_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_mode,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  irht_pkg::dp_sts_t   sts,
	output irht_pkg::dp_cmd_t   cmd
);
	import irht_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_DIV, S_MAP, S_RD, S_T1, S_T2, S_T3, S_DONE
	} state_t;

	state_t               state_q;
	logic [ADDR_W-1:0]    idx_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 out_valid_q;
	logic                 accept, last_slot;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
	assign accept    = in_ready && in_valid;
	assign last_slot = CNT_W'(idx_q) + CNT_W'(1) == sts.count;

	always_comb begin
		cmd.start    = accept;
		cmd.we       = accept && !in_mode;
		cmd.div      = state_q == S_DIV;
		cmd.map      = state_q == S_MAP;
		cmd.rd       = state_q == S_RD;
		cmd.t1       = state_q == S_T1;
		cmd.t2       = state_q == S_T2;
		cmd.set_hit  = state_q == S_T3 && sts.hit;
		cmd.out_load = state_q == S_DONE && (!out_valid_q || out_ready);
		cmd.addr     = idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					div_cnt_q <= '0;
					if (accept) begin
						state_q <= in_mode ? S_DIV : S_DONE;
					end
				end
				S_DIV: begin
					if (div_cnt_q == DIV_CNT_W'(PROD_W - 1)) begin
						state_q <= S_MAP;
					end
					div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
				end
				S_MAP: begin
					idx_q   <= '0;
					state_q <= (sts.count == '0) ? S_DONE : S_RD;
				end
				S_RD: state_q <= S_T1;
				S_T1: state_q <= S_T2;
				S_T2: state_q <= S_T3;
				S_T3: begin
					if (sts.hit || last_slot) begin
						state_q <= S_DONE;
					end else begin
						idx_q   <= idx_q + ADDR_W'(1);
						state_q <= S_RD;
					end
				end
				S_DONE: begin
					if (cmd.out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a waiting word is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result word overwritten");

	// the walk never reads past the searched slots
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> (CNT_W'(idx_q) < sts.count))
		else $error("slot walk beyond count");

	// a query always runs the full division before mapping
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.map |-> $past(state_q == S_DIV) && $past(div_cnt_q) == DIV_CNT_W'(PROD_W - 1))
		else $error("division cut short");
endmodule

// File: design/image_region_hit_test.sv
// Query: accept, then the division (S_DIV), the map step, and S_RD, S_T1, S_T2, S_T3 for each
// searched slot, up to 64 slots, then the load into the output register, which waits while a word is unread.
// Load: the slot RAM is written on accept. One item is in work at a time; the next
// is taken once the result sits in the output register.
// Reset: arst_n clears control and config registers; region slots hold no reset value.
// ----------------------------------------------------------------------------
// image_region_hit_test - top level
// Region slot store and point hit test, controller plus datapath.
// ----------------------------------------------------------------------------
module image_region_hit_test (
	input  logic       clk,
	input  logic       arst_n,
	irht_req_if.sink   req,
	irht_rsp_if.source rsp,
	irht_cfg_if.sink   cfg
);
	import irht_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg.ready = 1'b1;

	irht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_mode   (req.data.mode),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	irht_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_data (req.data),
		.cfg_we   (cfg.valid),
		.cfg_addr (cfg.addr),
		.cfg_data (cfg.data),
		.cmd      (cmd),
		.sts      (sts),
		.rsp_data (rsp.data)
	);
endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for image_region_hit_test
// Loads rectangle and circle slots, runs point queries under several scaling
// and mirroring settings, and checks every response word against an in-bench
// prediction of the slot store, the point mapping and the first-hit walk.
// ----------------------------------------------------------------------------
module tb_top;
	import irht_pkg::*;

	localparam longint COORD_MAX = (64'sd1 <<< (COORD_W - 1)) - 1;
	localparam longint COORD_MIN = -COORD_MAX - 1;

	class hit_scoreboard;
		region_t      slots [MAX_REGIONS];
		logic [22:0]  tot_w, tot_h;
		logic [15:0]  disp_w, disp_h;
		logic         mir_h, mir_v;
		logic [6:0]   n_search;
		rsp_t         pending_rsp [$];
		int           errors;

		function new();
			tot_w = 0; tot_h = 0; disp_w = 1; disp_h = 1;
			mir_h = 0; mir_v = 0; n_search = 0; errors = 0;
		endfunction

		function void set_reg(cfg_reg_t r, logic [CFG_W-1:0] v);
			case (r)
				REG_TOTAL_W:  tot_w = v[22:0];
				REG_TOTAL_H:  tot_h = v[22:0];
				REG_DISP_W:   disp_w = v[15:0];
				REG_DISP_H:   disp_h = v[15:0];
				REG_MIRROR_H: mir_h = v[0];
				REG_MIRROR_V: mir_v = v[0];
				REG_COUNT:    n_search = v[6:0];
				default: ;
			endcase
		endfunction

		function longint sat(longint v);
			if (v > COORD_MAX) return COORD_MAX;
			if (v < COORD_MIN) return COORD_MIN;
			return v;
		endfunction

		function longint map_axis(logic [22:0] tot, logic [15:0] disp, logic [15:0] q,
				logic mir);
			longint d, v;
			d = (disp == 0) ? 1 : longint'(disp);
			v = sat((longint'(tot) * longint'(q)) / d);
			if (mir)
				v = sat(longint'(tot) - v);
			return v;
		endfunction

		function bit contains(region_t r, longint x, longint y);
			longint x0, x1, y0, y1, dx, dy, r1;
			if (!r.kind) begin
				x0 = longint'(r.ax); x1 = longint'(r.bx);
				y0 = longint'(r.ay); y1 = longint'(r.by);
				if (x0 > x1) begin x0 = longint'(r.bx); x1 = longint'(r.ax); end
				if (y0 > y1) begin y0 = longint'(r.by); y1 = longint'(r.ay); end
				return x >= x0 && x <= x1 && y >= y0 && y <= y1;
			end
			dx = longint'(r.ax) - x;
			dy = longint'(r.ay) - y;
			r1 = longint'(r.bx) + 1;
			// magnitudes stay below 2^26, so the squares fit comfortably
			return dx * dx + dy * dy < r1 * r1;
		endfunction

		function void note_word(req_t it);
			rsp_t    e;
			longint  x, y;
			int      n;
			e = '0;
			if (!it.mode) begin
				slots[it.slot].kind   = it.kind;
				slots[it.slot].active = it.active;
				slots[it.slot].ax     = it.corner_a_x;
				slots[it.slot].ay     = it.corner_a_y;
				if (!it.kind) begin
					slots[it.slot].bx = it.corner_b_x;
					slots[it.slot].by = it.corner_b_y;
				end else begin
					slots[it.slot].bx = {1'b0, it.radius};
					slots[it.slot].by = '0;
				end
			end else begin
				x = map_axis(tot_w, disp_w, it.query_x, mir_h);
				y = map_axis(tot_h, disp_h, it.query_y, mir_v);
				n = (int'(n_search) > MAX_REGIONS) ? MAX_REGIONS : int'(n_search);
				for (int i = 0; i < n; i++) begin
					if (contains(slots[i], x, y)) begin
						if (slots[i].active) begin
							e.hit_found = 1'b1;
							e.hit_slot  = i[SLOT_W-1:0];
						end
						break;
					end
				end
				e.mapped_x = x[COORD_W-1:0];
				e.mapped_y = y[COORD_W-1:0];
			end
			pending_rsp.push_back(e);
		endfunction

		function void check_word(rsp_t got);
			rsp_t e;
			if (pending_rsp.size() == 0) begin
				$error("unexpected response word %p", got);
				errors++;
				return;
			end
			e = pending_rsp.pop_front();
			if (got.hit_found !== e.hit_found) begin
				$error("hit_found: expected %0d, got %0d", e.hit_found, got.hit_found);
				errors++;
			end
			if (got.hit_slot !== e.hit_slot) begin
				$error("hit_slot: expected %0d, got %0d", e.hit_slot, got.hit_slot);
				errors++;
			end
			if (got.mapped_x !== e.mapped_x) begin
				$error("mapped_x: expected %0d, got %0d", e.mapped_x, got.mapped_x);
				errors++;
			end
			if (got.mapped_y !== e.mapped_y) begin
				$error("mapped_y: expected %0d, got %0d", e.mapped_y, got.mapped_y);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   gaps_on = 1'b1;

	irht_req_if req_ch ();
	irht_rsp_if rsp_ch ();
	irht_cfg_if cfg_ch ();

	hit_scoreboard sb = new();

	image_region_hit_test i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source),
		.cfg    (cfg_ch.sink)
	);

	always #5 clk = ~clk;

	initial begin
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.addr  = '0;
		cfg_ch.data  = '0;
	end

	task automatic send_word(req_t it);
		int g;
		g = gaps_on ? $urandom_range(0, 3) : 0;
		if (g > 0) begin
			req_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= it;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_word(it);
	endtask

	task automatic write_reg(cfg_reg_t r, logic [CFG_W-1:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.addr  <= r;
		cfg_ch.data  <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		sb.set_reg(r, v);
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		while (sb.pending_rsp.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_scaling(logic [22:0] tw, logic [22:0] th, logic [15:0] dw,
			logic [15:0] dh, logic mh, logic mv, logic [6:0] cnt);
		drain();
		write_reg(REG_TOTAL_W, tw);
		write_reg(REG_TOTAL_H, th);
		write_reg(REG_DISP_W, CFG_W'(dw));
		write_reg(REG_DISP_H, CFG_W'(dh));
		write_reg(REG_MIRROR_H, CFG_W'(mh));
		write_reg(REG_MIRROR_V, CFG_W'(mv));
		write_reg(REG_COUNT, CFG_W'(cnt));
	endtask

	function automatic req_t load_word(int s, bit k, bit act, int ax, int ay, int bx, int by,
			int rad);
		req_t it;
		it = '0;
		it.mode = 1'b0; it.slot = s[SLOT_W-1:0]; it.kind = k; it.active = act;
		it.corner_a_x = ax[23:0]; it.corner_a_y = ay[23:0];
		it.corner_b_x = bx[23:0]; it.corner_b_y = by[23:0];
		it.radius = rad[22:0];
		return it;
	endfunction

	function automatic req_t query_word(int qx, int qy);
		req_t it;
		it = '0;
		it.mode = 1'b1; it.query_x = qx[15:0]; it.query_y = qy[15:0];
		// junk in the unused fields must not matter
		it.slot = SLOT_W'($urandom); it.corner_a_x = COORD_W'($urandom);
		it.corner_b_y = COORD_W'($urandom);
		it.radius = RAD_W'($urandom);
		return it;
	endfunction

	// coordinate near the mapped span, so that hits are common
	function automatic int near_coord(longint span);
		longint v;
		v = longint'($urandom_range(0, 1000)) * (span + 20) / 1000 - span / 16 - 10;
		return int'(v > COORD_MAX ? COORD_MAX : v);
	endfunction

	function automatic req_t random_load(int s, longint sx, longint sy);
		req_t it;
		int   ax, ay;
		if ($urandom_range(0, 9) == 0) begin
			it = '0;
			it.mode = 1'b0;
			{it.slot, it.kind, it.active} = 8'($urandom);
			it.corner_a_x = COORD_W'($urandom); it.corner_a_y = COORD_W'($urandom);
			it.corner_b_x = COORD_W'($urandom); it.corner_b_y = COORD_W'($urandom);
			it.radius = RAD_W'($urandom);
			it.query_x = DISP_W'($urandom); it.query_y = DISP_W'($urandom);
			it.slot = s[SLOT_W-1:0];
			return it;
		end
		ax = near_coord(sx);
		ay = near_coord(sy);
		return load_word(s, 1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0, ax, ay,
			ax + int'($urandom_range(0, 1000) * (sx / 4 + 2) / 1000)
				* ($urandom_range(0, 1) ? 1 : -1),
			ay + int'($urandom_range(0, 1000) * (sy / 4 + 2) / 1000)
				* ($urandom_range(0, 1) ? 1 : -1),
			int'($urandom_range(0, 1000) * ((sx + sy) / 12 + 2) / 1000));
	endfunction

	initial begin
		int     n_words;
		longint sx, sy;
		logic [22:0] tw, th;
		logic [15:0] dw, dh;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset scaling: total 0, nothing searched
		send_word(query_word(65535, 0));
		send_word(query_word(0, 65535));

		// circle boundary, radius extremes, inactive shadowing, full-range rectangle
		send_word(load_word(0, 1'b1, 1'b1, 20, 20, 0, 0, 3));
		send_word(load_word(1, 1'b1, 1'b1, -8388608, 0, 0, 0, 8388607));
		send_word(load_word(2, 1'b0, 1'b0, 40, 40, 30, 30, 0));
		send_word(load_word(3, 1'b0, 1'b1, 8388607, 8388607, -8388608, -8388608, 0));
		send_word(load_word(4, 1'b1, 1'b1, 60000, 60000, 0, 0, 0));
		for (int s = 5; s < MAX_REGIONS; s++)
			send_word(random_load(s, 70000, 70000));

		set_scaling(23'd1, 23'd1, 16'd1, 16'd1, 1'b0, 1'b0, 7'd64);
		send_word(query_word(23, 20));
		send_word(query_word(24, 20));
		send_word(query_word(22, 22));
		send_word(query_word(23, 23));
		send_word(query_word(30, 30));
		send_word(query_word(40, 35));
		send_word(query_word(41, 41));
		send_word(query_word(65535, 65535));
		set_scaling(23'd1, 23'd1, 16'd1, 16'd1, 1'b1, 1'b1, 7'd2);
		send_word(query_word(0, 0));
		send_word(query_word(65535, 65535));
		set_scaling(23'h7FFFFF, 23'h7FFFFF, 16'd0, 16'hFFFF, 1'b0, 1'b1, 7'd127);
		send_word(query_word(65535, 65535));
		send_word(query_word(1, 1));

		n_words = 0;
		for (int ph = 0; n_words < 420; ph++) begin
			case (ph % 6)
				0: begin tw = 100000; th = 50000; dw = 1000; dh = 500; end
				1: begin tw = 23'h7FFFFF; th = 23'h7FFFFF; dw = 1; dh = 65535; end
				2: begin tw = 1000; th = 3000; dw = 0; dh = 0; end
				default: begin
					tw = 23'($urandom); th = 23'($urandom);
					dw = 16'($urandom_range(0, 65535)); dh = 16'($urandom_range(1, 65535));
				end
			endcase
			set_scaling(tw, th, dw, dh, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				(ph % 3 == 0) ? 7'd64 : 7'($urandom_range(0, 127)));
			sx = (longint'(tw) * 65535) / (dw == 0 ? 1 : dw);
			sy = (longint'(th) * 65535) / (dh == 0 ? 1 : dh);
			if (sx > COORD_MAX) sx = COORD_MAX;
			if (sy > COORD_MAX) sy = COORD_MAX;
			gaps_on = (ph % 4 != 3);
			for (int k = 0; k < 60; k++) begin
				if ($urandom_range(0, 9) < 3)
					send_word(random_load($urandom_range(0, 63), sx, sy));
				else if ($urandom_range(0, 3) == 0)
					send_word(query_word($urandom, $urandom));
				else
					send_word(query_word($urandom_range(0, 2000) * 65535 / 2000,
						$urandom_range(0, 2000) * 65535 / 2000));
				n_words++;
			end
		end

		drain();
		repeat (300) @(posedge clk);
		if (sb.errors == 0 && sb.pending_rsp.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// response side: random back-pressure, with runs of none
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			g = gaps_on ? $urandom_range(0, 3) : 0;
			if (g > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			sb.check_word(rsp_ch.data);
		end
	end

	initial begin
		#30_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: files.f
design/irht_pkg.sv
design/irht_if.sv
design/irht_ram.sv
design/irht_dp.sv
design/irht_ctrl.sv
design/image_region_hit_test.sv
bench/tb_top.sv
